// ===== rtl/mcp_pkg.sv =====
// shared types and constants of the midpoint circle point generator
package mcp_pkg;

  // input item kind, carried in bit 0 of the slave tuser
  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_e;

  // eight symmetric points per emission
  localparam int unsigned NUM_POINTS = 8;
  localparam int unsigned IDX_BITS   = $clog2(NUM_POINTS);
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_POINTS - 1);

  // point index bits: negate x part, negate y part, swap x and y
  localparam int unsigned IDX_NEG_A = 0;
  localparam int unsigned IDX_NEG_B = 1;
  localparam int unsigned IDX_SWAP  = 2;

  // handoff control from the octant tracker to the point emitter
  typedef struct packed {
    logic load;
    logic done;
  } load_ctrl_t;

endpackage

// ===== rtl/midpoint_circle_points.sv =====
// top level of the midpoint circle point generator
//
//  channel  dir  tdata (low bit up)                 tuser        tlast
//  s_axis   in   center_x, center_y, radius, pad    func         -
//  m_axis   out  point_x, point_y, pad              circle_done  last_of_step
//
// a start or an active step is taken while the emitter has room and yields
// eight points, one per cycle unless m_axis stalls; the point emitter has a
// single output port and takes no new item until its eighth point is sent.
// a step while idle is taken and yields nothing.
// s_axis_tready_o rises in the cycle of the eighth point transfer, so the
// next item follows without a gap; an m_axis stall holds the current point.
// reset clears the emitter and returns the tracker to idle.
module midpoint_circle_points #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // center_x, center_y, radius, zero pad
  input  logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // func
  input  logic [0:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // point_x, point_y, zero pad
  output logic [((2*(COORD_BITS+1)+7)/8)*8-1:0] m_axis_tdata_o,
  // circle_done
  output logic [0:0]          m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  localparam int unsigned OUT_W = ((2*(COORD_BITS+1)+7)/8)*8;

  mcp_pkg::load_ctrl_t          ctrl;
  logic                         room;
  logic signed [COORD_BITS-1:0] rec_cx, rec_cy;
  logic [RADIUS_BITS-1:0]       rec_x, rec_y;
  logic signed [COORD_BITS:0]   point_x, point_y;
  logic                         done;

  // octant tracker
  mcp_octant #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_octant (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .func_i    (s_axis_tuser_i[0]),
    .center_x_i(s_axis_tdata_i[COORD_BITS-1:0]),
    .center_y_i(s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]),
    .radius_i  (s_axis_tdata_i[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
    .room_i    (room),
    .ctrl_o    (ctrl),
    .rec_cx_o  (rec_cx),
    .rec_cy_o  (rec_cy),
    .rec_x_o   (rec_x),
    .rec_y_o   (rec_y)
  );

  // point emitter
  mcp_emit #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .rec_cx_i   (rec_cx),
    .rec_cy_i   (rec_cy),
    .rec_x_i    (rec_x),
    .rec_y_i    (rec_y),
    .room_o     (room),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .point_x_o  (point_x),
    .point_y_o  (point_y),
    .last_o     (m_axis_tlast_o),
    .done_o     (done)
  );

  // pack the point
  assign m_axis_tdata_o = OUT_W'({point_y, point_x});
  assign m_axis_tuser_o = done;

endmodule

// ===== rtl/mcp_octant.sv =====
// octant tracker: midpoint decision update and circle state
module mcp_octant #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic signed [COORD_BITS-1:0]  center_x_i,
  input  logic signed [COORD_BITS-1:0]  center_y_i,
  input  logic [RADIUS_BITS-1:0]        radius_i,
  input  logic                          room_i,
  output mcp_pkg::load_ctrl_t           ctrl_o,
  output logic signed [COORD_BITS-1:0]  rec_cx_o,
  output logic signed [COORD_BITS-1:0]  rec_cy_o,
  output logic [RADIUS_BITS-1:0]        rec_x_o,
  output logic [RADIUS_BITS-1:0]        rec_y_o
);

  localparam int unsigned DEC_BITS = RADIUS_BITS + 3;

  logic                         active_q, active_d;
  logic signed [COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [RADIUS_BITS-1:0]       ox_q, ox_d, oy_q, oy_d;
  logic signed [DEC_BITS-1:0]   dec_q, dec_d;
  logic                         accept;
  logic                         is_start;
  logic                         emits;
  logic                         done;
  logic signed [DEC_BITS-1:0]   x_ext, y_ext;

  assign in_ready_o = room_i;
  assign accept     = in_valid_i && room_i;
  assign is_start   = (func_i == mcp_pkg::FUNC_START);
  assign emits      = is_start || active_q;

  assign x_ext = $signed({{(DEC_BITS-RADIUS_BITS){1'b0}}, ox_q});
  assign y_ext = $signed({{(DEC_BITS-RADIUS_BITS){1'b0}}, oy_q});

  // next offset and decision for start or one midpoint step
  always_comb begin
    cx_d  = cx_q;
    cy_d  = cy_q;
    ox_d  = ox_q;
    oy_d  = oy_q;
    dec_d = dec_q;
    if (is_start) begin
      cx_d  = center_x_i;
      cy_d  = center_y_i;
      ox_d  = '0;
      oy_d  = radius_i;
      dec_d = DEC_BITS'(1) - $signed({{(DEC_BITS-RADIUS_BITS){1'b0}}, radius_i});
    end else if (dec_q[DEC_BITS-1]) begin
      dec_d = dec_q + (x_ext <<< 1) + DEC_BITS'(3);
      ox_d  = ox_q + RADIUS_BITS'(1);
    end else begin
      dec_d = dec_q + ((x_ext - y_ext) <<< 1) + DEC_BITS'(5);
      ox_d  = ox_q + RADIUS_BITS'(1);
      oy_d  = oy_q - RADIUS_BITS'(1);
    end
  end

  // circle ends once y no longer lies above x
  assign done     = !(oy_d > ox_d);
  assign active_d = done ? 1'b0 : 1'b1;

  // active flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (accept && emits) begin
      active_q <= active_d;
    end
  end

  // circle payload state
  always_ff @(posedge clk_i) begin
    if (accept && emits) begin
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      ox_q  <= ox_d;
      oy_q  <= oy_d;
      dec_q <= dec_d;
    end
  end

  assign ctrl_o.load = accept && emits;
  assign ctrl_o.done = done;
  assign rec_cx_o    = cx_d;
  assign rec_cy_o    = cy_d;
  assign rec_x_o     = ox_d;
  assign rec_y_o     = oy_d;

endmodule

// ===== rtl/mcp_emit.sv =====
// point emitter: holds one emission and sends its eight points
module mcp_emit #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcp_pkg::load_ctrl_t           ctrl_i,
  input  logic signed [COORD_BITS-1:0]  rec_cx_i,
  input  logic signed [COORD_BITS-1:0]  rec_cy_i,
  input  logic [RADIUS_BITS-1:0]        rec_x_i,
  input  logic [RADIUS_BITS-1:0]        rec_y_i,
  output logic                          room_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS:0]    point_x_o,
  output logic signed [COORD_BITS:0]    point_y_o,
  output logic                          last_o,
  output logic                          done_o
);

  localparam int unsigned SUM_BITS =
    ((COORD_BITS > RADIUS_BITS + 1) ? COORD_BITS : RADIUS_BITS + 1) + 2;

  logic                         valid_q;
  logic [mcp_pkg::IDX_BITS-1:0] idx_q;
  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  logic [RADIUS_BITS-1:0]       ox_q, oy_q;
  logic                         done_q;
  logic                         xfer;
  logic                         is_last;
  logic [RADIUS_BITS-1:0]       part_a, part_b;
  logic signed [SUM_BITS-1:0]   a_ext, b_ext, sum_x, sum_y;

  assign is_last = (idx_q == mcp_pkg::LAST_IDX);
  assign xfer    = valid_q && out_ready_i;
  assign room_o  = !valid_q || (xfer && is_last);

  // emission valid and point index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (room_o) begin
      valid_q <= ctrl_i.load;
      idx_q   <= '0;
    end else if (xfer) begin
      idx_q <= idx_q + mcp_pkg::IDX_BITS'(1);
    end
  end

  // emission payload
  always_ff @(posedge clk_i) begin
    if (room_o && ctrl_i.load) begin
      cx_q   <= rec_cx_i;
      cy_q   <= rec_cy_i;
      ox_q   <= rec_x_i;
      oy_q   <= rec_y_i;
      done_q <= ctrl_i.done;
    end
  end

  // select the symmetric offset for this point and add it to the centre
  assign part_a = idx_q[mcp_pkg::IDX_SWAP] ? oy_q : ox_q;
  assign part_b = idx_q[mcp_pkg::IDX_SWAP] ? ox_q : oy_q;
  assign a_ext  = $signed({{(SUM_BITS-RADIUS_BITS){1'b0}}, part_a});
  assign b_ext  = $signed({{(SUM_BITS-RADIUS_BITS){1'b0}}, part_b});
  assign sum_x  = SUM_BITS'(cx_q) + (idx_q[mcp_pkg::IDX_NEG_A] ? -a_ext : a_ext);
  assign sum_y  = SUM_BITS'(cy_q) + (idx_q[mcp_pkg::IDX_NEG_B] ? -b_ext : b_ext);

  assign out_valid_o = valid_q;
  assign point_x_o   = sum_x[COORD_BITS:0];
  assign point_y_o   = sum_y[COORD_BITS:0];
  assign last_o      = is_last;
  assign done_o      = is_last && done_q;

endmodule

// ===== rtl/mcp_checker.sv =====
// port-level checks of the midpoint circle point generator, bound to the top level
module mcp_checker #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 11
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input logic [0:0]          s_axis_tuser_i,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [((2*(COORD_BITS+1)+7)/8)*8-1:0] m_axis_tdata_o,
  input logic [0:0]          m_axis_tuser_o,
  input logic                m_axis_tlast_o
);

  logic start_xfer;

  assign start_xfer = s_axis_tvalid_i && s_axis_tready_o &&
                      (s_axis_tuser_i[0] == mcp_pkg::FUNC_START);

  // a stalled point holds its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("stalled point changed");

  // circle end only on the last point of an emission
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tlast_o)
    else $error("circle_done without tlast");

  // no new item while an emission is short of its last point
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input taken mid emission");

  // a start always produces points in the next cycle
  a_start_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_xfer |=> m_axis_tvalid_o)
    else $error("start without emission");

endmodule

bind midpoint_circle_points mcp_checker #(
  .COORD_BITS (COORD_BITS),
  .RADIUS_BITS(RADIUS_BITS)
) u_mcp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tdata_i (s_axis_tdata_i),
  .s_axis_tuser_i (s_axis_tuser_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

// ===== dv/testbench.sv =====
// self-checking testbench for the midpoint circle point generator
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned RADIUS_W  = 11;
  localparam int unsigned POINT_W   = COORD_W + 1;
  localparam int unsigned S_DATA_W  = ((2*COORD_W+RADIUS_W+7)/8)*8;
  localparam int unsigned M_DATA_W  = ((2*POINT_W+7)/8)*8;
  localparam int unsigned STALL_MAX = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 15;

  // one input item of the stream
  typedef struct {
    mcp_pkg::func_e             func;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic [RADIUS_W-1:0]        radius;
  } circle_item_t;

  // one plotted point with its markers
  typedef struct {
    logic [POINT_W-1:0] px;
    logic [POINT_W-1:0] py;
    logic               last_of_step;
    logic               circle_done;
  } circle_point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                m_axis_tlast;

  circle_item_t  pending_items[$];
  circle_point_t expected_points[$];
  circle_item_t  presented_item;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;

  // circle tracker state mirrored from the block
  int trk_x = 0;
  int trk_y = 0;
  int trk_d = 0;
  int trk_cx = 0;
  int trk_cy = 0;
  bit trk_active = 1'b0;

  midpoint_circle_points #(
    .COORD_BITS (COORD_W),
    .RADIUS_BITS(RADIUS_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // apply one accepted item to the tracker and queue the eight points it yields, none for an idle step
  task automatic plot_circle_item(input circle_item_t it);
    bit done;
    int a;
    int b;
    circle_point_t pt;
    if (it.func == mcp_pkg::FUNC_START) begin
      trk_cx = it.cx;
      trk_cy = it.cy;
      trk_x = 0;
      trk_y = it.radius;
      trk_d = 1 - int'(it.radius);
      trk_active = 1'b1;
    end else if (!trk_active) begin
      return;
    end else if (trk_d < 0) begin
      trk_d = trk_d + 2*trk_x + 3;
      trk_x = trk_x + 1;
    end else begin
      trk_d = trk_d + 2*(trk_x - trk_y) + 5;
      trk_x = trk_x + 1;
      trk_y = trk_y - 1;
    end
    done = !(trk_y > trk_x);
    if (done) trk_active = 1'b0;
    // octant mirroring: bit 2 swaps x and y, bits 0 and 1 negate
    for (int k = 0; k < mcp_pkg::NUM_POINTS; k++) begin
      a = k[mcp_pkg::IDX_SWAP] ? trk_y : trk_x;
      b = k[mcp_pkg::IDX_SWAP] ? trk_x : trk_y;
      pt.px = POINT_W'(trk_cx + (k[mcp_pkg::IDX_NEG_A] ? -a : a));
      pt.py = POINT_W'(trk_cy + (k[mcp_pkg::IDX_NEG_B] ? -b : b));
      pt.last_of_step = (k == mcp_pkg::NUM_POINTS - 1);
      pt.circle_done = (k == mcp_pkg::NUM_POINTS - 1) && done;
      expected_points = {expected_points, pt};
    end
  endtask

  task automatic queue_start(input int cx, input int cy, input int r);
    circle_item_t it;
    it.func = mcp_pkg::FUNC_START;
    it.cx = COORD_W'(cx);
    it.cy = COORD_W'(cy);
    it.radius = RADIUS_W'(r);
    pending_items = {pending_items, it};
  endtask

  // step items carry random content in the unused fields
  task automatic queue_steps(input int n);
    circle_item_t it;
    for (int i = 0; i < n; i++) begin
      it.func = mcp_pkg::FUNC_STEP;
      it.cx = COORD_W'($urandom);
      it.cy = COORD_W'($urandom);
      it.radius = RADIUS_W'($urandom);
      pending_items = {pending_items, it};
    end
  endtask

  // mostly small circles run to completion, some cut short, a few huge ones
  task automatic queue_random_circles(input int unsigned n_items);
    int unsigned queued;
    int r;
    int n;
    queued = 0;
    while (queued < n_items) begin
      if ($urandom_range(9) == 0) r = $urandom_range(2047);
      else r = $urandom_range(24);
      if (r > 24) n = $urandom_range(4);
      else if ($urandom_range(5) == 0) n = $urandom_range(r);
      else n = $urandom_range(r + 1, (r * 2) / 3);
      queue_start($urandom_range(4095), $urandom_range(4095), r);
      queue_steps(n);
      queued += n + 1;
    end
  endtask

  task automatic drain_pending();
    while (pending_items.size() > 0) @(posedge clk_i);
  endtask

  // stimulus and end of run
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle step, zero radius, tiny circles, extremes, restart
    queue_steps(1);
    queue_start(0, 0, 0);
    queue_steps(1);
    queue_start(-2048, 2047, 1);
    queue_steps(2);
    queue_start(2047, -2048, 2047);
    queue_steps(3);
    queue_start(-1, -1, 5);
    queue_steps(5);
    queue_start(2047, 2047, 2047);
    queue_steps(2);
    queue_start(-2048, -2048, 2047);
    queue_steps(1);
    queue_start(0, 0, 3);
    queue_steps(3);

    // no idling
    queue_random_circles(ITEMS_PER_PHASE);
    drain_pending();
    // sender idle
    send_idle_pct = 60;
    recv_stall_pct = 0;
    queue_random_circles(ITEMS_PER_PHASE);
    drain_pending();
    // receiver stalling
    send_idle_pct = 0;
    recv_stall_pct = 60;
    queue_random_circles(ITEMS_PER_PHASE);
    drain_pending();
    // both
    send_idle_pct = 33;
    recv_stall_pct = 33;
    queue_random_circles(ITEMS_PER_PHASE);
    drain_pending();

    while (s_axis_tvalid || expected_points.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) plot_circle_item(presented_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          presented_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= S_DATA_W'({presented_item.radius, presented_item.cy,
                                     presented_item.cx});
          s_axis_tuser <= presented_item.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and point checker
  always @(posedge clk_i or negedge rst_ni) begin
    circle_point_t want;
    circle_point_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got.px = m_axis_tdata[POINT_W-1:0];
        got.py = m_axis_tdata[2*POINT_W-1:POINT_W];
        got.last_of_step = m_axis_tlast;
        got.circle_done = m_axis_tuser[0];
        if (expected_points.size() == 0) begin
          err_count++;
          $display("%0t: unexpected point x=%0d y=%0d last=%0b done=%0b", $time,
                   $signed(got.px), $signed(got.py), got.last_of_step, got.circle_done);
        end else begin
          want = expected_points.pop_front();
          if (got.px !== want.px || got.py !== want.py ||
              got.last_of_step !== want.last_of_step ||
              got.circle_done !== want.circle_done) begin
            err_count++;
            $display("%0t: mismatch expected %0d %0d %0b %0b actual %0d %0d %0b %0b",
                     $time, $signed(want.px), $signed(want.py), want.last_of_step,
                     want.circle_done, $signed(got.px), $signed(got.py),
                     got.last_of_step, got.circle_done);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_MAX);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
